FILE: design/bsfa_pkg.sv
// Shared types and constants for the battery SoC fusion and alarm unit.
// Used by bsfa_div, bsfa_alarm and battery_soc_fusion_alarm_unit.
`default_nettype none

package bsfa_pkg;

   // shared divider sizing
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 17;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_VOLT  = 3'd0,
      REG_WARN_VOLT = 3'd1,
      REG_CRIT_VOLT = 3'd2,
      REG_CAPACITY  = 3'd3,
      REG_FUSE_EN   = 3'd4
   } csr_index_type;

   // alarm machine control from the sequencer
   typedef struct packed {
      logic step;
      logic present;
      logic low_warn_en;
   } alarm_ctrl_type;

   // alarm machine results for the current update
   typedef struct packed {
      logic [1:0] status;
      logic [1:0] warn_level;
      logic [1:0] beep;
      logic       low;
      logic       crit;
   } alarm_out_type;

endpackage

`default_nettype wire

FILE: design/bsfa_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Sizing defaults come from bsfa_pkg.
`default_nettype none

module bsfa_div #(
   parameter int NUM_W = bsfa_pkg::DIV_NUM_W,
   parameter int DEN_W = bsfa_pkg::DIV_DEN_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic      [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] quot_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] dsr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             take;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, quot_ff[NUM_W-1]};
      take   = trial >= {1'b0, dsr_ff};
      diff   = trial - {1'b0, dsr_ff};
      rem_in = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[NUM_W-2:0], take};
         rem_ff  <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

FILE: design/bsfa_alarm.sv
// Battery status machine with hysteresis, beep code and failsafe flags.
// Uses alarm_ctrl_type and alarm_out_type from bsfa_pkg.
`default_nettype none

module bsfa_alarm (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bsfa_pkg::alarm_ctrl_type ctrl,
   input  wire logic [7:0]               soc,
   output bsfa_pkg::alarm_out_type       result
);

   typedef enum logic [1:0] {
      ST_NONE = 2'd0,
      ST_OK   = 2'd1,
      ST_WARN = 2'd2,
      ST_CRIT = 2'd3
   } state_type;

   localparam logic [1:0] BEEP_OFF  = 2'd0;
   localparam logic [1:0] BEEP_LOW  = 2'd1;
   localparam logic [1:0] BEEP_CRIT = 2'd2;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_LOW  = 2'd1;
   localparam logic [1:0] MODE_DEEP = 2'd2;

   localparam logic [7:0] WARN_ENTER = 8'd18;
   localparam logic [7:0] WARN_LEAVE = 8'd22;
   localparam logic [7:0] CRIT_ENTER = 8'd8;
   localparam logic [7:0] CRIT_LEAVE = 8'd12;
   localparam logic [7:0] DEEP_LEVEL = 8'd14;

   state_type  state_ff, state_in, entry;
   logic [1:0] mode_ff, mode_in;
   logic       low_ff, low_in;
   logic       crit_ff, crit_in;
   logic [1:0] beep;

   always_comb begin
      entry = state_ff;
      if (state_ff == ST_NONE && ctrl.present) begin
         entry = ST_OK;
      end else if (state_ff != ST_NONE && !ctrl.present) begin
         entry = ST_NONE;
      end

      state_in = entry;
      mode_in  = mode_ff;
      low_in   = low_ff;
      crit_in  = crit_ff;
      beep     = BEEP_OFF;

      unique case (entry)
         ST_NONE: begin
         end
         ST_OK: begin
            if (soc <= WARN_ENTER && ctrl.low_warn_en) begin
               state_in = ST_WARN;
               low_in   = 1'b1;
               beep     = BEEP_LOW;
            end
         end
         ST_WARN: begin
            if (soc <= CRIT_ENTER) begin
               state_in = ST_CRIT;
               crit_in  = 1'b1;
               low_in   = 1'b0;
               beep     = BEEP_CRIT;
            end else if (soc > WARN_LEAVE) begin
               state_in = ST_OK;
               low_in   = 1'b0;
               mode_in  = MODE_NONE;
            end else begin
               beep    = BEEP_LOW;
               mode_in = (soc <= DEEP_LEVEL) ? MODE_DEEP : MODE_LOW;
            end
         end
         ST_CRIT: begin
            if (soc > CRIT_LEAVE) begin
               state_in = ST_WARN;
               low_in   = 1'b1;
               crit_in  = 1'b0;
               beep     = BEEP_LOW;
            end else begin
               beep = BEEP_CRIT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_NONE;
         mode_ff  <= MODE_NONE;
         low_ff   <= 1'b0;
         crit_ff  <= 1'b0;
      end else if (ctrl.step) begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         low_ff   <= low_in;
         crit_ff  <= crit_in;
      end
   end

   always_comb begin
      result.status     = state_in;
      result.warn_level = mode_in;
      result.beep       = beep;
      result.low        = low_in;
      result.crit       = crit_in;
   end

endmodule

`default_nettype wire

FILE: design/battery_soc_fusion_alarm_unit.sv
// Battery SoC fusion and low-battery alarm, top level: sequencer and blend datapath.
// Depends on bsfa_pkg, bsfa_div and bsfa_alarm.
//
// Usage:
//   req_*  : one battery update per transfer (voltage, remaining charge, flags).
//   rsp_*  : one result per update (fused SoC, status, warning level, beep, flags).
//   csr_*  : register writes, index 0..4, always ready; write only while idle.
// Each update runs through one shared 32-step divider three times (voltage SoC,
// charge SoC, dominance bias), then the blend multiply states S_MUL_A and
// S_MUL_B and the percent scaling state S_SCALE on the shared multiplier.
// req_tready is low from the accepting edge until the sequencer is idle again;
// the next update can be accepted in the cycle after the previous result is
// loaded into the output register.
// A result waits in the output register while rsp_tready is low; the next
// update is still accepted and computed, then the sequencer holds its result
// (req_tready low) until the output register is free, so nothing is lost.
// Reset (synchronous, active high) loads the default register values, the
// charge weight of 55 %, a previous SoC of 100 and the not-present status.
`default_nettype none

module battery_soc_fusion_alarm_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // [15:0] compensated_voltage_mv, [31:16] remaining_mah, [32] armed,
   // [33] low_warning_enable, [34] battery_present, [39:35] zero
   input  wire logic [39:0]                         req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [7:0] fused_soc_pct, [9:8] battery_status, [11:10] warning_level,
   // [13:12] beep_code, [14] low_battery_indicator, [15] inflight_low_indicator
   output logic [15:0]                              rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bsfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bsfa_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int NUM_W = bsfa_pkg::DIV_NUM_W;
   localparam int DEN_W = bsfa_pkg::DIV_DEN_W;

   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_DIV_V = 3'd1,
      S_DIV_C = 3'd2,
      S_DIV_B = 3'd3,
      S_MUL_A = 3'd4,
      S_MUL_B = 3'd5,
      S_SCALE = 3'd6,
      S_DONE  = 3'd7
   } seq_state_type;

   // Q8.8 percent constants
   localparam logic [14:0] Q_FULL    = 15'd25600;
   localparam logic [14:0] Q_W_LOW   = 15'd7680;
   localparam logic [14:0] Q_W_MID   = 15'd14080;
   localparam logic [14:0] Q_W_HIGH  = 15'd17920;
   localparam logic [14:0] Q_W_MIN   = 15'd5120;
   localparam logic [14:0] Q_W_MAX   = 15'd19200;
   localparam logic [15:0] Q_FLOOR   = 16'd6400;
   localparam logic [14:0] Q_ARMED   = 15'd1024;
   localparam logic [15:0] Q_STEP    = 16'd512;
   localparam logic [11:0] Q_BIAS    = 12'd3072;
   localparam logic [17:0] Q_CLAMP   = 18'd131072;
   localparam logic signed [35:0] TOTAL_FULL = 36'sd655360000;
   // x / 100 == (x * 5243) >> 19 for x up to 10000
   localparam logic signed [16:0] RECIP_100 = 17'sd5243;

   seq_state_type state_ff;

   // configuration
   logic [15:0] max_ff, warn_ff, crit_ff, cap_ff;
   logic        fuse_en_ff;

   // captured update
   logic [15:0] volt_ff, rem_ff;
   logic        armed_ff, lwe_ff, present_ff;

   // intermediate results
   logic signed [18:0] socv_ff;
   logic [14:0]        socah_ff;
   logic [14:0]        w_new_ff;
   logic signed [35:0] acc_ff;
   logic [7:0]         soc_fuse_ff;

   // persistent fusion state
   logic [14:0] weight_ff;
   logic [7:0]  prev_ff;

   logic        start_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;

   // divider
   logic             div_done;
   logic [NUM_W-1:0] div_q;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;

   // voltage geometry
   logic signed [17:0] z_s, nv_s, den_s, span_s;
   logic [17:0]        nv_neg, den_neg;
   logic [16:0]        nv_mag, den_mag;
   logic               v_le_w, v_le_z, span_pos;
   logic [16:0]        depth;
   logic [NUM_W-1:0]   num_v, num_c, num_b;
   logic [13:0]        pct_num;

   // per-stage next values
   logic [17:0]        qc;
   logic signed [18:0] socv_in;
   logic [14:0]        socah_in;
   logic [11:0]        bias;
   logic [22:0]        rem100, cap15, cap85;
   logic [14:0]        t0, t1, t2, t3, w_in;
   logic [15:0]        w_up;
   logic [7:0]         fo, lim1, soc_fuse_in;
   logic [7:0]         socv_pct;

   // shared multiplier
   logic signed [18:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [35:0] prod;

   logic                    out_free;
   logic                    commit;
   logic [7:0]              soc_sel;
   bsfa_pkg::alarm_ctrl_type alarm_ctrl;
   bsfa_pkg::alarm_out_type  alarm_out;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == S_DONE) && out_free;

   always_comb begin
      z_s     = $signed({2'b00, crit_ff}) - 18'sd100;
      nv_s    = $signed({2'b00, volt_ff}) - z_s;
      den_s   = $signed({2'b00, max_ff}) - z_s;
      span_s  = $signed({2'b00, warn_ff}) - z_s;
      nv_neg  = -nv_s;
      den_neg = -den_s;
      nv_mag  = nv_s[17] ? nv_neg[16:0] : nv_s[16:0];
      den_mag = den_s[17] ? den_neg[16:0] : den_s[16:0];
      v_le_w  = volt_ff <= warn_ff;
      v_le_z  = $signed({2'b00, volt_ff}) <= z_s;
      span_pos = !span_s[17] && (span_s != 18'sd0);
      depth   = v_le_z ? span_s[16:0] : {1'b0, warn_ff - volt_ff};
      num_v   = NUM_W'(nv_mag) * NUM_W'(25600);
      num_c   = NUM_W'(rem_ff) * NUM_W'(25600);
      num_b   = NUM_W'(depth) * NUM_W'(3072);

      if (acc_ff[35] || acc_ff == 36'sd0) begin
         pct_num = 14'd0;
      end else if (acc_ff >= TOTAL_FULL) begin
         pct_num = 14'd10000;
      end else begin
         pct_num = acc_ff[29:16];
      end
   end

   always_comb begin
      case (state_ff)
         S_DIV_V: begin
            div_num = num_v;
            div_den = den_mag;
         end
         S_DIV_C: begin
            div_num = num_c;
            div_den = {1'b0, cap_ff};
         end
         default: begin
            div_num = num_b;
            div_den = span_s[16:0];
         end
      endcase
   end

   bsfa_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // voltage SoC, charge SoC, weight target
   always_comb begin
      qc = (div_q > NUM_W'(Q_CLAMP)) ? Q_CLAMP : div_q[17:0];
      if (den_s == 18'sd0) begin
         socv_in = 19'sd0;
      end else if (nv_s[17] ^ den_s[17]) begin
         socv_in = -$signed({1'b0, qc});
      end else begin
         socv_in = $signed({1'b0, qc});
      end

      if (cap_ff == 16'd0) begin
         socah_in = 15'd0;
      end else if (rem_ff >= cap_ff) begin
         socah_in = Q_FULL;
      end else begin
         socah_in = div_q[14:0];
      end

      rem100 = 23'(rem_ff) * 23'd100;
      cap15  = 23'(cap_ff) * 23'd15;
      cap85  = 23'(cap_ff) * 23'd85;
      if (cap_ff == 16'd0 || rem100 <= cap15) begin
         t0 = Q_W_LOW;
      end else if (rem_ff >= cap_ff || rem100 >= cap85) begin
         t0 = Q_W_HIGH;
      end else begin
         t0 = Q_W_MID;
      end

      bias = span_pos ? div_q[11:0] : Q_BIAS;
      if (v_le_w && {1'b0, t0} > Q_FLOOR + {4'd0, bias}) begin
         t1 = t0 - {3'd0, bias};
      end else begin
         t1 = t0;
      end
      t2 = (armed_ff && {1'b0, t1} > Q_FLOOR) ? t1 - Q_ARMED : t1;
      if (t2 < Q_W_MIN) begin
         t3 = Q_W_MIN;
      end else if (t2 > Q_W_MAX) begin
         t3 = Q_W_MAX;
      end else begin
         t3 = t2;
      end

      w_up = {1'b0, weight_ff} + Q_STEP;
      if ({1'b0, t3} > w_up) begin
         w_in = w_up[14:0];
      end else if ({1'b0, t3} + Q_STEP < {1'b0, weight_ff}) begin
         w_in = weight_ff - Q_STEP[14:0];
      end else begin
         w_in = t3;
      end
   end

   // blend products and percent scaling
   always_comb begin
      case (state_ff)
         S_MUL_B: begin
            mul_a = socv_ff;
            mul_b = $signed(17'd25600 - {2'b00, w_new_ff});
         end
         S_SCALE: begin
            mul_a = $signed({5'd0, pct_num});
            mul_b = RECIP_100;
         end
         default: begin
            mul_a = $signed({4'd0, socah_ff});
            mul_b = $signed({2'b00, w_new_ff});
         end
      endcase
      prod = mul_a * mul_b;
   end

   // rate limit and voltage-only percent
   always_comb begin
      fo = prod[26:19];
      if (armed_ff) begin
         lim1 = (fo > prev_ff) ? prev_ff : fo;
         soc_fuse_in = (prev_ff - lim1 > 8'd2) ? prev_ff - 8'd2 : lim1;
      end else begin
         lim1 = prev_ff + 8'd1;
         soc_fuse_in = ({1'b0, fo} > {1'b0, prev_ff} + 9'd1) ? lim1 : fo;
      end

      if (socv_ff[18]) begin
         socv_pct = 8'd0;
      end else if (socv_ff[17:8] > 10'd255) begin
         socv_pct = 8'd255;
      end else begin
         socv_pct = socv_ff[15:8];
      end

      soc_sel = fuse_en_ff ? soc_fuse_ff : socv_pct;
   end

   always_comb begin
      alarm_ctrl.step        = commit;
      alarm_ctrl.present     = present_ff;
      alarm_ctrl.low_warn_en = lwe_ff;
   end

   bsfa_alarm u_alarm (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alarm_ctrl),
      .soc    (soc_sel),
      .result (alarm_out)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff     <= 16'd4200;
         warn_ff    <= 16'd3500;
         crit_ff    <= 16'd3300;
         cap_ff     <= 16'd1000;
         fuse_en_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            bsfa_pkg::REG_MAX_VOLT:  max_ff     <= csr_data;
            bsfa_pkg::REG_WARN_VOLT: warn_ff    <= csr_data;
            bsfa_pkg::REG_CRIT_VOLT: crit_ff    <= csr_data;
            bsfa_pkg::REG_CAPACITY:  cap_ff     <= csr_data;
            bsfa_pkg::REG_FUSE_EN:   fuse_en_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         weight_ff    <= Q_W_MID;
         prev_ff      <= 8'd100;
      end else begin
         start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  volt_ff    <= req_tdata[15:0];
                  rem_ff     <= req_tdata[31:16];
                  armed_ff   <= req_tdata[32];
                  lwe_ff     <= req_tdata[33];
                  present_ff <= req_tdata[34];
                  start_ff   <= 1'b1;
                  state_ff   <= S_DIV_V;
               end
            end
            S_DIV_V: begin
               if (div_done) begin
                  socv_ff  <= socv_in;
                  start_ff <= 1'b1;
                  state_ff <= S_DIV_C;
               end
            end
            S_DIV_C: begin
               if (div_done) begin
                  socah_ff <= socah_in;
                  start_ff <= 1'b1;
                  state_ff <= S_DIV_B;
               end
            end
            S_DIV_B: begin
               if (div_done) begin
                  w_new_ff <= w_in;
                  state_ff <= S_MUL_A;
               end
            end
            S_MUL_A: begin
               acc_ff   <= prod;
               state_ff <= S_MUL_B;
            end
            S_MUL_B: begin
               acc_ff   <= acc_ff + prod;
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               soc_fuse_ff <= soc_fuse_in;
               state_ff    <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {alarm_out.crit, alarm_out.low, alarm_out.beep,
                                   alarm_out.warn_level, alarm_out.status, soc_sel};
                  if (fuse_en_ff) begin
                     weight_ff <= w_new_ff;
                     prev_ff   <= soc_fuse_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire
